// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the tick-driven task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

   // default table size, and cap on tasks run by one dispatch
   localparam int MAX_TASKS_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

   localparam int TAG_W = 8;
   localparam int CD_W  = 32;
   localparam int PEND_W = 8;

   // request modes
   localparam logic [1:0] MODE_ADD      = 2'd0;
   localparam logic [1:0] MODE_TICK     = 2'd1;
   localparam logic [1:0] MODE_DISPATCH = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_RUN   = 2'd0;
   localparam logic [1:0] STAT_ADDED = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_IDLE  = 2'd3;

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   // one row of the task table
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [CD_W-1:0]   countdown;
      logic [CD_W-1:0]   period;
      logic [PEND_W-1:0] pending;
   } entry_type;

   // per-entry outcome of the update unit
   typedef struct packed {
      logic run;    // task dispatched on this visit
      logic drop;   // one-shot task leaves the table
   } upd_status_type;

endpackage

// ===== rtl/tts_ram.sv =====
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tts_entry_unit.sv =====
// ----------------------------------------------------------------------------
// tts_entry_unit
// Shared update unit: applies a tick or a dispatch visit to one table row.
// ----------------------------------------------------------------------------
module tts_entry_unit (
   input  logic                    is_tick,
   input  logic                    room,      // result cap not yet reached
   input  tts_pkg::entry_type      entry_cur,
   output tts_pkg::entry_type      entry_nxt,
   output tts_pkg::upd_status_type upd
);
   import tts_pkg::*;

   logic cd_zero;
   logic pend_zero;

   assign cd_zero   = (entry_cur.countdown == '0);
   assign pend_zero = (entry_cur.pending == '0);

   always_comb begin
      entry_nxt = entry_cur;
      upd       = '0;
      if (is_tick) begin
         if (!cd_zero) begin
            entry_nxt.countdown = entry_cur.countdown - CD_W'(1);
         end else begin
            entry_nxt.countdown = entry_cur.period;
            if (entry_cur.pending != PEND_MAX) begin
               entry_nxt.pending = entry_cur.pending + PEND_W'(1);
            end
         end
      end else if (!pend_zero && room) begin
         entry_nxt.pending = entry_cur.pending - PEND_W'(1);
         upd.run           = 1'b1;
         upd.drop          = (entry_cur.period == '0);
      end
   end

endmodule

// ===== rtl/tick_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler
// Cooperative time-triggered task scheduler over an ordered table of tasks.
// ----------------------------------------------------------------------------
// Sequence: add gives its result from S_ADD; dispatch walks the N live rows in
//   S_WALK, then gives its final result from S_FINISH; output stalls hold both.
// Throughput: one request at a time; the input stalls until an add, tick or
//   dispatch is done. The walk visits one row per cycle unless a run waits
//   on the output, through the single RAM port pair and shared row update unit.
// Reset: clears the task count, sequencer, run counter and output valid;
//   table contents are left as they are and are never used beyond the live count.
// ----------------------------------------------------------------------------
module tick_task_scheduler #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [tts_pkg::TAG_W-1:0]  req_task_tag,
   input  logic [tts_pkg::CD_W-1:0]   req_start_delay,
   input  logic [tts_pkg::CD_W-1:0]   req_repeat_period,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tts_pkg::TAG_W-1:0]  rsp_run_tag,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_last
);
   import tts_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_WALK,
      S_FINISH
   } state_type;

   // control state
   state_type          state_ff,      state_in;
   logic [CNT_W-1:0]   count_ff,      count_in;     // live tasks
   logic [CNT_W-1:0]   proc_idx_ff,   proc_idx_in;  // row whose data is at RAM out
   logic [CNT_W-1:0]   keep_ff,       keep_in;      // compaction write pointer
   logic [EMIT_W-1:0]  emit_ff,       emit_in;      // tasks run this dispatch
   logic               held_valid_ff, held_valid_in;
   logic               rsp_valid_ff,  rsp_valid_in;

   // payload
   logic [1:0]         mode_ff,       mode_in;
   logic [TAG_W-1:0]   tag_ff,        tag_in;
   logic [CD_W-1:0]    delay_ff,      delay_in;
   logic [CD_W-1:0]    period_ff,     period_in;
   logic [TAG_W-1:0]   held_tag_ff,   held_tag_in;  // latest run, awaits last flag
   logic [TAG_W-1:0]   rsp_tag_ff,    rsp_tag_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff,   rsp_last_in;

   // RAM port signals
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   entry_type          ram_rd_data;

   // row update unit
   entry_type          entry_nxt;
   upd_status_type     upd;
   logic               is_tick;
   logic               room;

   logic               req_xfer;
   logic               out_free;
   logic               last_row;
   logic               go;
   logic [CNT_W-1:0]   proc_nxt;
   entry_type          new_entry;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // output register may take a new transfer when empty or draining now
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_tick   = (mode_ff == MODE_TICK);
   assign room      = (emit_ff < EMIT_W'(MAX_RESULTS));
   assign proc_nxt  = proc_idx_ff + CNT_W'(1);
   assign last_row  = (proc_nxt == count_ff);

   // a second run needs the previous one pushed out first
   assign go = !(upd.run && held_valid_ff) || out_free;

   assign new_entry.tag       = tag_ff;
   assign new_entry.countdown = delay_ff;
   assign new_entry.period    = period_ff;
   assign new_entry.pending   = '0;

   tts_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_TASKS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tts_entry_unit u_unit (
      .is_tick   (is_tick),
      .room      (room),
      .entry_cur (ram_rd_data),
      .entry_nxt (entry_nxt),
      .upd       (upd)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      proc_idx_in   = proc_idx_ff;
      keep_in       = keep_ff;
      emit_in       = emit_ff;
      held_valid_in = held_valid_ff;
      held_tag_in   = held_tag_ff;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_W-1:0];
      ram_wr_data   = new_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mode_in       = req_mode;
               tag_in        = req_task_tag;
               delay_in      = req_start_delay;
               period_in     = req_repeat_period;
               proc_idx_in   = '0;
               keep_in       = '0;
               emit_in       = '0;
               held_valid_in = 1'b0;
               // row 0 is fetched straight away for a walk
               ram_rd_en     = 1'b1;
               case (req_mode)
                  MODE_ADD: state_in = S_ADD;
                  MODE_TICK: begin
                     if (count_ff != '0) begin
                        state_in = S_WALK;
                     end
                  end
                  MODE_DISPATCH: begin
                     state_in = (count_ff != '0) ? S_WALK : S_FINISH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_last_in  = 1'b1;
               if (count_ff >= CNT_W'(MAX_TASKS)) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  rsp_status_in = STAT_ADDED;
                  ram_wr_en     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end

         S_WALK: begin
            if (go) begin
               if (is_tick) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = proc_idx_ff[IDX_W-1:0];
                  ram_wr_data = entry_nxt;
               end else begin
                  if (!upd.drop) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = keep_ff[IDX_W-1:0];
                     ram_wr_data = entry_nxt;
                     keep_in     = keep_ff + CNT_W'(1);
                  end
                  if (upd.run) begin
                     if (held_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_tag_in    = held_tag_ff;
                        rsp_status_in = STAT_RUN;
                        rsp_last_in   = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_tag_in   = ram_rd_data.tag;
                     emit_in       = emit_ff + EMIT_W'(1);
                  end
               end
               if (last_row) begin
                  state_in = is_tick ? S_IDLE : S_FINISH;
               end else begin
                  proc_idx_in = proc_nxt;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = proc_nxt[IDX_W-1:0];
               end
            end
         end

         S_FINISH: begin
            // close the dispatch: final run, or nothing ready
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_tag_in    = held_valid_ff ? held_tag_ff : '0;
               rsp_status_in = held_valid_ff ? STAT_RUN : STAT_IDLE;
               held_valid_in = 1'b0;
               count_in      = keep_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tag_ff        <= tag_in;
      delay_ff      <= delay_in;
      period_ff     <= period_in;
      held_tag_ff   <= held_tag_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      proc_idx_ff   <= proc_idx_in;
      keep_ff       <= keep_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         emit_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         emit_ff       <= emit_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_run_tag = rsp_tag_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count above table size");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_RUN |-> rsp_last)
      else $error("non-run response without last flag");

   a_walk_ptrs: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> keep_ff <= proc_idx_ff && proc_idx_ff < count_ff)
      else $error("walk pointers out of order");

   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      emit_ff <= EMIT_W'(MAX_RESULTS))
      else $error("dispatch ran more tasks than allowed");

endmodule

// ===== tb/sched_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_monitor
// Watches both channels of the task scheduler, keeps its own copy of the task
// table to predict every response, and compares each response transfer with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sched_monitor #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [tts_pkg::TAG_W-1:0]  req_task_tag,
   input  logic [tts_pkg::CD_W-1:0]   req_start_delay,
   input  logic [tts_pkg::CD_W-1:0]   req_repeat_period,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [tts_pkg::TAG_W-1:0]  rsp_run_tag,
   input  logic [1:0]                 rsp_status,
   input  logic                       rsp_last,
   output int                         mismatches,
   output int                         outstanding,
   output int                         responses_seen
);
   import tts_pkg::*;

   typedef struct packed {
      logic [TAG_W-1:0] run_tag;
      logic [1:0]       status;
      logic             last;
   } sched_result_type;

   // predicted task table
   logic [TAG_W-1:0]  tsk_tag       [MAX_TASKS];
   logic [CD_W-1:0]   tsk_countdown [MAX_TASKS];
   logic [CD_W-1:0]   tsk_period    [MAX_TASKS];
   logic [PEND_W-1:0] tsk_pending   [MAX_TASKS];
   int                tsk_live;

   sched_result_type due_results[$];
   int               errs;
   int               seen;

   task automatic schedule_request(input logic [1:0] mode, input logic [TAG_W-1:0] tag,
                                   input logic [CD_W-1:0] delay,
                                   input logic [CD_W-1:0] period);
      int               keep;
      int               ran;
      bit               drop;
      sched_result_type tail;
      case (mode)
         MODE_ADD: begin
            if (tsk_live >= MAX_TASKS) begin
               due_results.push_back({8'h00, STAT_FULL, 1'b1});
            end else begin
               tsk_tag[tsk_live]       = tag;
               tsk_countdown[tsk_live] = delay;
               tsk_period[tsk_live]    = period;
               tsk_pending[tsk_live]   = '0;
               tsk_live++;
               due_results.push_back({8'h00, STAT_ADDED, 1'b1});
            end
         end
         MODE_TICK: begin
            for (int i = 0; i < tsk_live; i++) begin
               if (tsk_countdown[i] != '0) begin
                  tsk_countdown[i] = tsk_countdown[i] - 1'b1;
               end else begin
                  tsk_countdown[i] = tsk_period[i];
                  if (tsk_pending[i] != PEND_MAX)
                     tsk_pending[i] = tsk_pending[i] + 1'b1;
               end
            end
         end
         MODE_DISPATCH: begin
            keep = 0;
            ran  = 0;
            for (int i = 0; i < tsk_live; i++) begin
               drop = 1'b0;
               if (tsk_pending[i] != '0 && ran < MAX_RESULTS) begin
                  tsk_pending[i] = tsk_pending[i] - 1'b1;
                  due_results.push_back({tsk_tag[i], STAT_RUN, 1'b0});
                  ran++;
                  drop = (tsk_period[i] == '0);
               end
               if (!drop) begin
                  // compact the table, order kept
                  tsk_tag[keep]       = tsk_tag[i];
                  tsk_countdown[keep] = tsk_countdown[i];
                  tsk_period[keep]    = tsk_period[i];
                  tsk_pending[keep]   = tsk_pending[i];
                  keep++;
               end
            end
            tsk_live = keep;
            if (ran == 0) begin
               due_results.push_back({8'h00, STAT_IDLE, 1'b1});
            end else begin
               tail      = due_results.pop_back();
               tail.last = 1'b1;
               due_results.push_back(tail);
            end
         end
         default: ;  // spare mode: no effect
      endcase
   endtask

   initial begin
      errs           = 0;
      seen           = 0;
      tsk_live       = 0;
      mismatches     = 0;
      outstanding    = 0;
      responses_seen = 0;
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         tsk_live = 0;
         due_results.delete();
      end else begin
         if (req_valid && !req_stall)
            schedule_request(req_mode, req_task_tag, req_start_delay, req_repeat_period);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (due_results.size() == 0) begin
               $error("unexpected response: run_tag %0h status %0d last %0b",
                      rsp_run_tag, rsp_status, rsp_last);
               errs++;
            end else begin
               want = due_results.pop_front();
               if (rsp_run_tag !== want.run_tag) begin
                  $error("run_tag: expected %0h, actual %0h", want.run_tag, rsp_run_tag);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  errs++;
               end
            end
         end
      end
      mismatches     <= errs;
      outstanding    <= due_results.size();
      responses_seen <= seen;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the tick-driven task scheduler: a directed opening
// (empty dispatch, extreme fields, one-shot removal, table full, a burst of
// runs from a full table), then random add/tick/dispatch traffic with random
// idling on both channels. Checking lives in sched_monitor.
// ----------------------------------------------------------------------------
module testbench;
   import tts_pkg::*;

   // mode 3 is not decoded by the block; it must be ignored
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 80;
   localparam int BUILD_TICKS  = 3;     // let pending runs build up on a full table
   localparam int CYCLE_LIMIT  = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_mode = MODE_TICK;
   logic [TAG_W-1:0]    req_task_tag = '0;
   logic [CD_W-1:0]     req_start_delay = '0;
   logic [CD_W-1:0]     req_repeat_period = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TAG_W-1:0]    rsp_run_tag;
   logic [1:0]          rsp_status;
   logic                rsp_last;

   int mismatches;
   int outstanding;
   int responses_seen;
   int cycles = 0;
   int n_add = 0, n_tick = 0, n_dispatch = 0, n_spare = 0;
   logic calm = 1'b0;   // high: neither side idles

   always #1 clock = ~clock;

   tick_task_scheduler i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_task_tag      (req_task_tag),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_run_tag       (rsp_run_tag),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   sched_monitor i_mon (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_task_tag      (req_task_tag),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_run_tag       (rsp_run_tag),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .responses_seen    (responses_seen)
   );

   // receiver back-pressure: stalls with about 18 percent odds, none during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= (!reset && !calm) ? ($urandom_range(99) < 18) : 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one request transfer; random idle cycles ahead of it unless calm
   task automatic issue(input logic [1:0] mode, input logic [TAG_W-1:0] tag,
                        input logic [CD_W-1:0] delay, input logic [CD_W-1:0] period);
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_task_tag      <= tag;
      req_start_delay   <= delay;
      req_repeat_period <= period;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (mode)
         MODE_ADD:      n_add++;
         MODE_TICK:     n_tick++;
         MODE_DISPATCH: n_dispatch++;
         default:       n_spare++;
      endcase
   endtask

   // hold off until every predicted response has arrived, then let the
   // longest table walk finish with margin
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int useful;
      int pick;
      logic [CD_W-1:0] dly;
      logic [CD_W-1:0] per;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed opening ---
      issue(MODE_DISPATCH, 8'h00, '0, '0);              // empty table: nothing ready
      issue(MODE_ADD, 8'h00, 32'h0, 32'h0);             // one-shot, fires on first tick
      issue(MODE_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(MODE_ADD, 8'hA5, 32'h1, 32'h1);
      issue(MODE_TICK, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(MODE_SPARE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(MODE_DISPATCH, 8'h00, '0, '0);              // one-shot runs and leaves
      issue(MODE_TICK, 8'h00, '0, '0);
      issue(MODE_DISPATCH, 8'h00, '0, '0);              // periodic task runs, stays
      // fill the table: two live tasks plus fourteen
      for (int k = 0; k < 14; k++)
         issue(MODE_ADD, 8'h10 + k[7:0], 32'h0, (k == 3 || k == 9) ? 32'h2 : 32'h0);
      issue(MODE_ADD, 8'h77, 32'h5, 32'h5);             // table full, rejected
      for (int k = 0; k < BUILD_TICKS; k++)
         issue(MODE_TICK, 8'($urandom), $urandom, $urandom);
      issue(MODE_DISPATCH, 8'h00, '0, '0);              // long burst of runs
      issue(MODE_DISPATCH, 8'h00, '0, '0);

      // --- random traffic ---
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         calm <= (useful >= 20 && useful < 50);
         if (useful == 60 && n_dispatch > 0)
            drain();
         pick = $urandom_range(99);
         dly  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
         case ($urandom_range(19))
            0, 1:    per = $urandom_range(1, 4);
            2:       per = $urandom;
            default: per = '0;
         endcase
         if (pick < 35) begin
            issue(MODE_ADD, 8'($urandom), dly, per);
            useful++;
         end else if (pick < 65) begin
            issue(MODE_TICK, 8'($urandom), $urandom, $urandom);
            useful++;
         end else if (pick < 95) begin
            issue(MODE_DISPATCH, 8'($urandom), $urandom, $urandom);
            useful++;
         end else begin
            issue(MODE_SPARE, 8'($urandom), $urandom, $urandom);
         end
         if (useful == 60)
            drain();
      end
      calm <= 1'b0;
      drain();

      $display("Requests: %0d add, %0d tick, %0d dispatch, %0d spare-mode (ignored)",
               n_add, n_tick, n_dispatch, n_spare);
      $display("Responses checked: %0d, incl. table-full, idle dispatch and run bursts",
               responses_seen);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tts_entry_unit.sv
rtl/tick_task_scheduler.sv
tb/sched_monitor.sv
tb/testbench.sv
